[src/dpm_pkg.sv]
// shared types and constants for the dense prim spanning tree block
package dpm_pkg;

    localparam int VERTEX_W   = 5;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_RUN   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 2'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD2,
        ST_INIT,
        ST_PASS,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]          operation;
        logic [VERTEX_W-1:0] end_a;
        logic [VERTEX_W-1:0] end_b;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_request;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [VERTEX_W-1:0] parent;
        logic [WEIGHT_W-1:0] tree_weight;
        logic                reached;
        logic                bad_start;
        logic                last;
    } t_result;

    typedef struct packed {
        logic init;
        logic relax;
        logic mark;
        logic shift;
    } t_cell_ctl;

endpackage

[src/dense_prim_mst_top.sv]
// top level: weight matrix memory, run sequencer and the row of vertex cells
//
// usage: a request is taken at a rising edge with start high and busy low.
// a load request writes the edge weight into both symmetric matrix cells.
// a clear request zeroes the matrix, one cell a cycle; the same clearing pass
// runs after reset, with busy high.
// a run request starts a tree from start_vertex. each round streams one
// matrix row into the cells while a min token walks the cell row; a run whose
// tree holds r vertices makes r rounds before the first result.
// results then come one per cycle, vertex 0 to vertex_count-1, each on
// o_result for one cycle with o_result_strobe high, the final one marked last.
// a run with a bad start gives one result, in the cycle after the request.
// the receiver cannot stall; results are never held back.
// configuration writes (vertex_count, start_vertex) are taken at any edge
// with i_cfg_we high and are meant for idle periods.
module dense_prim_mst_top import dpm_pkg::*; #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_request              i_request,
    output logic                  o_result_strobe,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int VW        = $clog2(MAX_VERTICES);
    localparam int CW        = $clog2(MAX_VERTICES + 1);
    localparam int PW        = $clog2(MAX_VERTICES + 3);
    localparam int WB        = WEIGHT_BITS;
    localparam int MEM_DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [AW-1:0] CLR_LAST  = AW'(MEM_DEPTH - 1);
    localparam logic [PW-1:0] PASS_END  = PW'(MAX_VERTICES + 2);
    localparam logic [PW-1:0] PASS_COLS = PW'(MAX_VERTICES);
    localparam logic [6:0]    VMAX      = 7'(MAX_VERTICES);

    function automatic logic [AW-1:0] addr_of(input logic [VW-1:0] row,
                                              input logic [VW-1:0] col);
        return AW'(AW'(row) * AW'(MAX_VERTICES)) + AW'(col);
    endfunction

    t_state        r_state;
    t_state        n_state;
    logic [PW-1:0] r_cnt;
    logic [AW-1:0] r_clr;
    logic [VW-1:0] r_u;
    logic [CW-1:0] r_n;
    logic [VW-1:0] r_a;
    logic [VW-1:0] r_b;
    logic [WB-1:0] r_w;
    logic [6:0]    r_vcount;
    logic [4:0]    r_start;
    logic [WB-1:0] r_rd_data;
    logic          r_rd_vld;
    logic [VW-1:0] r_rd_idx;
    logic          r_res_vld;
    t_result       r_res;
    logic [WB-1:0] r_mem [MEM_DEPTH];

    logic          accept;
    logic [6:0]    vc_eff;
    logic          bad_run;
    logic          load_ok;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WB-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_cell_ctl     ctl;
    logic [VW-1:0] cell_idx;
    logic          emit_last;

    logic          tok_found [MAX_VERTICES+1];
    logic [WB-1:0] tok_key   [MAX_VERTICES+1];
    logic [VW-1:0] tok_idx   [MAX_VERTICES+1];
    logic          st_in_tree [MAX_VERTICES];
    logic          st_known   [MAX_VERTICES];
    logic [WB-1:0] st_key     [MAX_VERTICES];
    logic [VW-1:0] st_parent  [MAX_VERTICES];

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign vc_eff  = (r_vcount > VMAX) ? VMAX : r_vcount;
    assign bad_run = (7'(r_start) >= vc_eff);
    assign load_ok = (7'(i_request.end_a) < VMAX) && (7'(i_request.end_b) < VMAX);
    assign emit_last = ((r_cnt + PW'(1)) == PW'(r_n));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLR_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    case (i_request.operation)
                        OP_LOAD:  n_state = load_ok ? ST_LOAD2 : ST_IDLE;
                        OP_RUN:   n_state = bad_run ? ST_IDLE : ST_INIT;
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD2: n_state = ST_IDLE;
            ST_INIT:  n_state = ST_PASS;
            ST_PASS: begin
                if (r_cnt == PASS_END) n_state = tok_found[MAX_VERTICES] ? ST_PASS : ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_of(VW'(i_request.end_a), VW'(i_request.end_b));
        mem_wdata = WB'(i_request.edge_weight);
        mem_raddr = addr_of(r_u, r_cnt[VW-1:0]);
        ctl       = '0;
        cell_idx  = r_rd_idx;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                mem_we = start && (i_request.operation == OP_LOAD) && load_ok;
            end
            ST_LOAD2: begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(r_b, r_a);
                mem_wdata = r_w;
            end
            ST_INIT: begin
                ctl.init = 1'b1;
            end
            ST_PASS: begin
                ctl.relax = r_rd_vld;
                if ((r_cnt == PASS_END) && tok_found[MAX_VERTICES]) begin
                    ctl.mark = 1'b1;
                    cell_idx = tok_idx[MAX_VERTICES];
                end
            end
            ST_EMIT: begin
                ctl.shift = 1'b1;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt[VW-1:0];
        if (accept) begin
            r_a <= VW'(i_request.end_a);
            r_b <= VW'(i_request.end_b);
            r_w <= WB'(i_request.edge_weight);
            r_u <= VW'(r_start);
            r_n <= CW'(vc_eff);
        end else if (ctl.mark) begin
            r_u <= tok_idx[MAX_VERTICES];
        end
        if (accept && bad_run) begin
            r_res <= '{vertex: '0, parent: '0, tree_weight: '0, reached: 1'b0,
                       bad_start: 1'b1, last: 1'b1};
        end else begin
            r_res.vertex      <= VERTEX_W'(r_cnt);
            r_res.parent      <= st_in_tree[0] ? VERTEX_W'(st_parent[0]) : '0;
            r_res.tree_weight <= st_in_tree[0] ? WEIGHT_W'(st_key[0]) : '0;
            r_res.reached     <= st_in_tree[0];
            r_res.bad_start   <= 1'b0;
            r_res.last        <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_res_vld <= 1'b0;
            r_vcount  <= VMAX;
            r_start   <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= (r_state == ST_PASS) && (r_cnt < PASS_COLS);
            r_res_vld <= (accept && (i_request.operation == OP_RUN) && bad_run)
                         || (r_state == ST_EMIT);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end else begin
                r_clr <= '0;
            end
            if ((r_state == ST_PASS) && (r_cnt == PASS_END)) begin
                r_cnt <= '0;
            end else if ((r_state == ST_PASS) || (r_state == ST_EMIT)) begin
                r_cnt <= r_cnt + PW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VERTEX_COUNT: r_vcount <= 7'(i_cfg_data);
                    CFG_START_VERTEX: r_start  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    assign tok_found[0] = 1'b0;
    assign tok_key[0]   = '0;
    assign tok_idx[0]   = '0;

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        localparam int NB = (k == MAX_VERTICES - 1) ? k : k + 1;
        dpm_cell #(
            .IDX (k),
            .VW  (VW),
            .CW  (CW),
            .WB  (WB)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_start      (r_u),
            .i_count      (r_n),
            .i_idx        (cell_idx),
            .i_weight     (r_rd_data),
            .i_parent     (r_u),
            .i_tok_found  (tok_found[k]),
            .i_tok_key    (tok_key[k]),
            .i_tok_idx    (tok_idx[k]),
            .o_tok_found  (tok_found[k+1]),
            .o_tok_key    (tok_key[k+1]),
            .o_tok_idx    (tok_idx[k+1]),
            .i_nb_in_tree (st_in_tree[NB]),
            .i_nb_known   (st_known[NB]),
            .i_nb_key     (st_key[NB]),
            .i_nb_parent  (st_parent[NB]),
            .o_in_tree    (st_in_tree[k]),
            .o_known      (st_known[k]),
            .o_key        (st_key[k]),
            .o_parent     (st_parent[k])
        );
    end

    assign o_result_strobe = r_res_vld;
    assign o_result        = r_res;

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> (($past(r_state) == ST_EMIT) || $past(accept)))
        else $error("result strobe without emit or request");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.last) |-> (r_state == ST_IDLE))
        else $error("last result but run still active");

    a_pick_unvisited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.mark |-> !st_in_tree[tok_idx[MAX_VERTICES]])
        else $error("chosen vertex already in tree");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CLEAR) && (r_clr == CLR_LAST)) |=> (r_state == ST_IDLE))
        else $error("clearing pass did not finish");

endmodule

[src/dpm_cell.sv]
// one vertex cell: key, parent and tree flags, relax update and min token stage
module dpm_cell import dpm_pkg::*; #(
    parameter int IDX = 0,
    parameter int VW  = 5,
    parameter int CW  = 6,
    parameter int WB  = 16
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [VW-1:0] i_start,
    input  logic [CW-1:0] i_count,
    input  logic [VW-1:0] i_idx,
    input  logic [WB-1:0] i_weight,
    input  logic [VW-1:0] i_parent,
    input  logic          i_tok_found,
    input  logic [WB-1:0] i_tok_key,
    input  logic [VW-1:0] i_tok_idx,
    output logic          o_tok_found,
    output logic [WB-1:0] o_tok_key,
    output logic [VW-1:0] o_tok_idx,
    input  logic          i_nb_in_tree,
    input  logic          i_nb_known,
    input  logic [WB-1:0] i_nb_key,
    input  logic [VW-1:0] i_nb_parent,
    output logic          o_in_tree,
    output logic          o_known,
    output logic [WB-1:0] o_key,
    output logic [VW-1:0] o_parent
);

    localparam logic [VW-1:0] MY_IDX = VW'(IDX);

    logic          r_in_tree;
    logic          r_known;
    logic [WB-1:0] r_key;
    logic [VW-1:0] r_parent;
    logic          r_tok_found;
    logic [WB-1:0] r_tok_key;
    logic [VW-1:0] r_tok_idx;
    logic          hit;
    logic          better;
    logic          take;

    assign hit    = (i_idx == MY_IDX);
    assign better = (i_weight != '0) && !r_in_tree && (!r_known || (i_weight < r_key));
    assign take   = !r_in_tree && r_known && (!i_tok_found || (r_key < i_tok_key));

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_in_tree <= !(CW'(IDX) < i_count) || (i_start == MY_IDX);
            r_known   <= (i_start == MY_IDX);
            r_key     <= '0;
            r_parent  <= i_start;
        end else if (i_ctl.shift) begin
            r_in_tree <= i_nb_in_tree;
            r_known   <= i_nb_known;
            r_key     <= i_nb_key;
            r_parent  <= i_nb_parent;
        end else if (i_ctl.mark && hit) begin
            r_in_tree <= 1'b1;
        end else if (i_ctl.relax && hit && better) begin
            r_key    <= i_weight;
            r_parent <= i_parent;
            r_known  <= 1'b1;
        end
    end

    // min token, ties keep the lower vertex
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok_found <= 1'b1;
            r_tok_key   <= r_key;
            r_tok_idx   <= MY_IDX;
        end else begin
            r_tok_found <= i_tok_found;
            r_tok_key   <= i_tok_key;
            r_tok_idx   <= i_tok_idx;
        end
    end

    assign o_tok_found = r_tok_found;
    assign o_tok_key   = r_tok_key;
    assign o_tok_idx   = r_tok_idx;
    assign o_in_tree   = r_in_tree;
    assign o_known     = r_known;
    assign o_key       = r_key;
    assign o_parent    = r_parent;

endmodule
